// File: rtl/core/pdtg_pkg.sv
// ----------------------------------------------------------------------------
// pdtg_pkg
// Shared widths, codes, state encoding and controller/datapath interface
// structs for the path distance trigger generator.
// ----------------------------------------------------------------------------
package pdtg_pkg;

   // field widths
   localparam int LEN_W      = 24;   // segment length, spacing, velocity
   localparam int POS_W      = 40;   // running length and positions
   localparam int NEXT_W     = POS_W + 1;
   localparam int SEG_CNT_W  = 16;   // segment index counter (SEGMENT_INDEX_BITS)
   localparam int SEG_OUT_W  = 16;
   localparam int TOTAL_W    = 32;
   localparam int TIME_W     = 40;
   localparam int HALF_W     = 20;   // multiplier operand split
   localparam int PROD_W     = POS_W + HALF_W;
   localparam int EMIT_CNT_W = 6;
   localparam int DIV_CNT_W  = 6;
   localparam int CSR_IDX_W  = 2;

   // per-segment trigger limit
   localparam logic [EMIT_CNT_W-1:0] MAX_TRIGGERS_PER_SEGMENT = EMIT_CNT_W'(63);

   // microseconds per second
   localparam logic [HALF_W-1:0] US_PER_S = HALF_W'(1000000);

   // quotient bits produced by the divider
   localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(TIME_W);

   // reset values of the configuration registers
   localparam logic [LEN_W-1:0] SPACING_RESET  = LEN_W'(1000);
   localparam logic [LEN_W-1:0] VELOCITY_RESET = LEN_W'(10000);

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_TRIGGER_SPACING = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_VELOCITY        = CSR_IDX_W'(1);

   // result kinds
   localparam logic KIND_TRIGGER = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_LOAD_TRIG,
      ST_LOAD_SUM,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_EMIT,
      ST_SKIP_START,
      ST_SKIP_WAIT,
      ST_SKIP_FIX
   } state_type;

   typedef struct packed {
      logic accept;       // take segment, update length and segment counter
      logic check;        // latch per-segment overflow mode
      logic load_trig;    // stage next trigger position, advance it
      logic load_sum;     // stage path length for summary
      logic mul_lo;       // low partial product
      logic mul_hi;       // high partial product, accumulate
      logic time_start;   // divider: product / velocity
      logic skip_start;   // divider: remaining distance mod spacing
      logic skip_fix;     // move next trigger past running length
      logic emit;         // load output register
   } cmd_type;

   typedef struct packed {
      logic due;          // a trigger falls inside the running length
      logic more_trig;    // another trigger follows the staged one
      logic ovf_mode;     // this segment exceeds the trigger limit
      logic last;         // current segment ends the path
      logic kind;         // kind of the staged result
      logic div_busy;
      logic out_free;     // output register can take a result
   } status_type;

endpackage

// File: rtl/core/pdtg_divider.sv
// ----------------------------------------------------------------------------
// pdtg_divider
// Restoring divider, one quotient bit per cycle. Dividend must be below
// divisor * 2^40; quotient is 40 bits, remainder 24 bits.
// ----------------------------------------------------------------------------
module pdtg_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [pdtg_pkg::PROD_W-1:0]      dividend,
   input  logic [pdtg_pkg::LEN_W-1:0]       divisor,
   output logic                             busy,
   output logic [pdtg_pkg::TIME_W-1:0]      quotient,
   output logic [pdtg_pkg::LEN_W-1:0]       remainder
);

   logic [pdtg_pkg::LEN_W-1:0]     rem_ff, rem_in;
   logic [pdtg_pkg::TIME_W-1:0]    quo_ff, quo_in;
   logic [pdtg_pkg::LEN_W-1:0]     dvs_ff, dvs_in;
   logic [pdtg_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [pdtg_pkg::LEN_W:0]       trial;
   logic                           fits;

   assign trial = {rem_ff, quo_ff[pdtg_pkg::TIME_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      if (start) begin
         rem_in = pdtg_pkg::LEN_W'(dividend[pdtg_pkg::PROD_W-1:pdtg_pkg::TIME_W]);
         quo_in = dividend[pdtg_pkg::TIME_W-1:0];
         dvs_in = divisor;
         cnt_in = pdtg_pkg::DIV_STEPS;
      end else if (cnt_ff != '0) begin
         rem_in = fits ? pdtg_pkg::LEN_W'(trial - {1'b0, dvs_ff})
                       : pdtg_pkg::LEN_W'(trial);
         quo_in = {quo_ff[pdtg_pkg::TIME_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy      = cnt_ff != '0;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// File: rtl/core/pdtg_datapath.sv
// ----------------------------------------------------------------------------
// pdtg_datapath
// Path state, configuration registers, time multiplier, shared divider and
// the output register.
// ----------------------------------------------------------------------------
module pdtg_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  pdtg_pkg::cmd_type                   cmd,
   output pdtg_pkg::status_type                status,
   input  logic [pdtg_pkg::LEN_W-1:0]          req_segment_length_um,
   input  logic                                req_last_segment,
   input  logic                                csr_write_enable,
   input  logic [pdtg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pdtg_pkg::LEN_W-1:0]          csr_write_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_kind,
   output logic [pdtg_pkg::POS_W-1:0]          rsp_position_um,
   output logic [pdtg_pkg::TIME_W-1:0]         rsp_time_us,
   output logic [pdtg_pkg::SEG_OUT_W-1:0]      rsp_segment_number,
   output logic [pdtg_pkg::TOTAL_W-1:0]        rsp_trigger_total,
   output logic                                rsp_overflow,
   output logic                                rsp_last_result
);

   localparam int XMAX_W = pdtg_pkg::LEN_W + pdtg_pkg::EMIT_CNT_W;
   localparam int CMP_W  = pdtg_pkg::NEXT_W + 1;

   // configuration
   logic [pdtg_pkg::LEN_W-1:0]      spacing_ff, spacing_in;
   logic [pdtg_pkg::LEN_W-1:0]      velocity_ff, velocity_in;

   // path state
   logic [pdtg_pkg::POS_W-1:0]      length_ff, length_in;
   logic [pdtg_pkg::NEXT_W-1:0]     next_ff, next_in;
   logic [pdtg_pkg::SEG_CNT_W-1:0]  segcnt_ff, segcnt_in;
   logic [pdtg_pkg::TOTAL_W-1:0]    trigcnt_ff, trigcnt_in;
   logic                            skipped_ff, skipped_in;

   // per-segment working registers
   logic                            last_ff, last_in;
   logic [pdtg_pkg::SEG_CNT_W-1:0]  seg_ff, seg_in;
   logic [pdtg_pkg::EMIT_CNT_W-1:0] emitcnt_ff, emitcnt_in;
   logic                            ovf_mode_ff, ovf_mode_in;
   logic                            kind_ff, kind_in;
   logic [pdtg_pkg::POS_W-1:0]      pos_ff, pos_in;
   logic [pdtg_pkg::PROD_W-1:0]     prod_ff, prod_in;

   // output register
   logic                            out_valid_ff, out_valid_in;
   logic                            out_kind_ff, out_kind_in;
   logic [pdtg_pkg::POS_W-1:0]      out_pos_ff, out_pos_in;
   logic [pdtg_pkg::TIME_W-1:0]     out_time_ff, out_time_in;
   logic [pdtg_pkg::SEG_OUT_W-1:0]  out_seg_ff, out_seg_in;
   logic [pdtg_pkg::TOTAL_W-1:0]    out_total_ff, out_total_in;
   logic                            out_ovf_ff, out_ovf_in;
   logic                            out_last_ff, out_last_in;

   // combinational helpers
   logic [pdtg_pkg::POS_W:0]        length_sum;
   logic [XMAX_W-1:0]               spacing_x_max;
   logic [CMP_W-1:0]                ovf_limit;
   logic                            due;
   logic                            ovf_now;
   logic                            more_trig;
   logic [pdtg_pkg::POS_W-1:0]      lo_prod, hi_prod;
   logic [pdtg_pkg::TIME_W-1:0]     time_val;
   logic                            div_start;
   logic [pdtg_pkg::PROD_W-1:0]     div_dividend;
   logic [pdtg_pkg::LEN_W-1:0]      div_divisor;
   logic                            div_busy;
   logic [pdtg_pkg::TIME_W-1:0]     div_quotient;
   logic [pdtg_pkg::LEN_W-1:0]      div_remainder;
   logic [pdtg_pkg::POS_W-1:0]      remaining;
   logic                            out_free;

   assign length_sum    = {1'b0, length_ff} + (pdtg_pkg::POS_W+1)'(req_segment_length_um);
   assign spacing_x_max = XMAX_W'(spacing_ff) * XMAX_W'(pdtg_pkg::MAX_TRIGGERS_PER_SEGMENT);
   assign ovf_limit     = {1'b0, next_ff} + CMP_W'(spacing_x_max);
   assign due           = (spacing_ff != '0) && ({1'b0, length_ff} >= next_ff);
   assign ovf_now       = CMP_W'(length_ff) >= ovf_limit;
   assign more_trig     = ovf_mode_ff ? (emitcnt_ff != pdtg_pkg::MAX_TRIGGERS_PER_SEGMENT)
                                      : ({1'b0, length_ff} >= next_ff);
   assign remaining     = length_ff - next_ff[pdtg_pkg::POS_W-1:0];

   assign lo_prod = pdtg_pkg::POS_W'(pos_ff[pdtg_pkg::HALF_W-1:0])
                  * pdtg_pkg::POS_W'(pdtg_pkg::US_PER_S);
   assign hi_prod = pdtg_pkg::POS_W'(pos_ff[pdtg_pkg::POS_W-1:pdtg_pkg::HALF_W])
                  * pdtg_pkg::POS_W'(pdtg_pkg::US_PER_S);

   // zero velocity gives zero time; a quotient past 40 bits saturates
   always_comb begin
      if (velocity_ff == '0) begin
         time_val = '0;
      end else if (pdtg_pkg::LEN_W'(prod_ff[pdtg_pkg::PROD_W-1:pdtg_pkg::TIME_W])
                   >= velocity_ff) begin
         time_val = '1;
      end else begin
         time_val = div_quotient;
      end
   end

   // divider shared between trigger times and the skip remainder
   assign div_start    = cmd.time_start | cmd.skip_start;
   assign div_dividend = cmd.skip_start ? pdtg_pkg::PROD_W'(remaining) : prod_ff;
   assign div_divisor  = cmd.skip_start ? spacing_ff : velocity_ff;

   pdtg_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      spacing_in  = spacing_ff;
      velocity_in = velocity_ff;
      length_in   = length_ff;
      next_in     = next_ff;
      segcnt_in   = segcnt_ff;
      trigcnt_in  = trigcnt_ff;
      skipped_in  = skipped_ff;
      last_in     = last_ff;
      seg_in      = seg_ff;
      emitcnt_in  = emitcnt_ff;
      ovf_mode_in = ovf_mode_ff;
      kind_in     = kind_ff;
      pos_in      = pos_ff;
      prod_in     = prod_ff;

      if (csr_write_enable) begin
         case (csr_index)
            pdtg_pkg::REG_TRIGGER_SPACING: begin
               spacing_in = csr_write_data;
               // between paths the new spacing also sets the first trigger
               if (length_ff == '0 && segcnt_ff == '0) begin
                  next_in = pdtg_pkg::NEXT_W'(csr_write_data);
               end
            end
            pdtg_pkg::REG_VELOCITY: begin
               velocity_in = csr_write_data;
            end
            default: begin
            end
         endcase
      end

      if (cmd.accept) begin
         length_in  = length_sum[pdtg_pkg::POS_W] ? '1 : length_sum[pdtg_pkg::POS_W-1:0];
         last_in    = req_last_segment;
         seg_in     = segcnt_ff;
         segcnt_in  = (segcnt_ff == '1) ? segcnt_ff : segcnt_ff + 1'b1;
         emitcnt_in = '0;
      end

      if (cmd.check) begin
         ovf_mode_in = due && ovf_now;
         if (due && ovf_now) begin
            skipped_in = 1'b1;
         end
      end

      if (cmd.load_trig) begin
         kind_in    = pdtg_pkg::KIND_TRIGGER;
         pos_in     = next_ff[pdtg_pkg::POS_W-1:0];
         next_in    = next_ff + pdtg_pkg::NEXT_W'(spacing_ff);
         emitcnt_in = emitcnt_ff + 1'b1;
         trigcnt_in = (trigcnt_ff == '1) ? trigcnt_ff : trigcnt_ff + 1'b1;
      end

      if (cmd.load_sum) begin
         kind_in = pdtg_pkg::KIND_SUMMARY;
         pos_in  = length_ff;
      end

      if (cmd.mul_lo) begin
         prod_in = pdtg_pkg::PROD_W'(lo_prod);
      end

      if (cmd.mul_hi) begin
         prod_in = prod_ff + {hi_prod, {pdtg_pkg::HALF_W{1'b0}}};
      end

      // first trigger position past the running length
      if (cmd.skip_fix) begin
         next_in = {1'b0, length_ff} - pdtg_pkg::NEXT_W'(div_remainder)
                 + pdtg_pkg::NEXT_W'(spacing_ff);
      end

      // summary ends the path
      if (cmd.emit && kind_ff == pdtg_pkg::KIND_SUMMARY) begin
         length_in  = '0;
         next_in    = pdtg_pkg::NEXT_W'(spacing_ff);
         segcnt_in  = '0;
         trigcnt_in = '0;
         skipped_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      out_kind_in  = out_kind_ff;
      out_pos_in   = out_pos_ff;
      out_time_in  = out_time_ff;
      out_seg_in   = out_seg_ff;
      out_total_in = out_total_ff;
      out_ovf_in   = out_ovf_ff;
      out_last_in  = out_last_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
         out_kind_in  = kind_ff;
         out_pos_in   = pos_ff;
         out_time_in  = time_val;
         out_seg_in   = pdtg_pkg::SEG_OUT_W'(seg_ff);
         out_total_in = trigcnt_ff;
         out_ovf_in   = skipped_ff;
         out_last_in  = (kind_ff == pdtg_pkg::KIND_SUMMARY) || (!more_trig && !last_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spacing_ff   <= pdtg_pkg::SPACING_RESET;
         velocity_ff  <= pdtg_pkg::VELOCITY_RESET;
         length_ff    <= '0;
         next_ff      <= pdtg_pkg::NEXT_W'(pdtg_pkg::SPACING_RESET);
         segcnt_ff    <= '0;
         trigcnt_ff   <= '0;
         skipped_ff   <= 1'b0;
         last_ff      <= 1'b0;
         emitcnt_ff   <= '0;
         ovf_mode_ff  <= 1'b0;
         kind_ff      <= pdtg_pkg::KIND_TRIGGER;
         out_valid_ff <= 1'b0;
      end else begin
         spacing_ff   <= spacing_in;
         velocity_ff  <= velocity_in;
         length_ff    <= length_in;
         next_ff      <= next_in;
         segcnt_ff    <= segcnt_in;
         trigcnt_ff   <= trigcnt_in;
         skipped_ff   <= skipped_in;
         last_ff      <= last_in;
         emitcnt_ff   <= emitcnt_in;
         ovf_mode_ff  <= ovf_mode_in;
         kind_ff      <= kind_in;
         out_valid_ff <= out_valid_in;
      end
      seg_ff       <= seg_in;
      pos_ff       <= pos_in;
      prod_ff      <= prod_in;
      out_kind_ff  <= out_kind_in;
      out_pos_ff   <= out_pos_in;
      out_time_ff  <= out_time_in;
      out_seg_ff   <= out_seg_in;
      out_total_ff <= out_total_in;
      out_ovf_ff   <= out_ovf_in;
      out_last_ff  <= out_last_in;
   end

   assign status.due       = due;
   assign status.more_trig = more_trig;
   assign status.ovf_mode  = ovf_mode_ff;
   assign status.last      = last_ff;
   assign status.kind      = kind_ff;
   assign status.div_busy  = div_busy;
   assign status.out_free  = out_free;

   assign rsp_valid          = out_valid_ff;
   assign rsp_kind           = out_kind_ff;
   assign rsp_position_um    = out_pos_ff;
   assign rsp_time_us        = out_time_ff;
   assign rsp_segment_number = out_seg_ff;
   assign rsp_trigger_total  = out_total_ff;
   assign rsp_overflow       = out_ovf_ff;
   assign rsp_last_result    = out_last_ff;

endmodule

// File: rtl/core/pdtg_controller.sv
// ----------------------------------------------------------------------------
// pdtg_controller
// Sequencer: segment intake, per-trigger multiply/divide/emit, skip fixup
// and path summary.
// ----------------------------------------------------------------------------
module pdtg_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  pdtg_pkg::status_type  status,
   output pdtg_pkg::cmd_type     cmd
);

   pdtg_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pdtg_pkg::ST_IDLE: begin
            if (req_valid) state_in = pdtg_pkg::ST_CHECK;
         end
         pdtg_pkg::ST_CHECK: begin
            if (status.due)       state_in = pdtg_pkg::ST_LOAD_TRIG;
            else if (status.last) state_in = pdtg_pkg::ST_LOAD_SUM;
            else                  state_in = pdtg_pkg::ST_IDLE;
         end
         pdtg_pkg::ST_LOAD_TRIG: state_in = pdtg_pkg::ST_MUL_LO;
         pdtg_pkg::ST_LOAD_SUM:  state_in = pdtg_pkg::ST_MUL_LO;
         pdtg_pkg::ST_MUL_LO:    state_in = pdtg_pkg::ST_MUL_HI;
         pdtg_pkg::ST_MUL_HI:    state_in = pdtg_pkg::ST_DIV_START;
         pdtg_pkg::ST_DIV_START: state_in = pdtg_pkg::ST_DIV_WAIT;
         pdtg_pkg::ST_DIV_WAIT: begin
            if (!status.div_busy) state_in = pdtg_pkg::ST_EMIT;
         end
         pdtg_pkg::ST_EMIT: begin
            if (status.out_free) begin
               if (status.kind == pdtg_pkg::KIND_SUMMARY) state_in = pdtg_pkg::ST_IDLE;
               else if (status.more_trig) state_in = pdtg_pkg::ST_LOAD_TRIG;
               else if (status.ovf_mode)  state_in = pdtg_pkg::ST_SKIP_START;
               else if (status.last)      state_in = pdtg_pkg::ST_LOAD_SUM;
               else                       state_in = pdtg_pkg::ST_IDLE;
            end
         end
         pdtg_pkg::ST_SKIP_START: state_in = pdtg_pkg::ST_SKIP_WAIT;
         pdtg_pkg::ST_SKIP_WAIT: begin
            if (!status.div_busy) state_in = pdtg_pkg::ST_SKIP_FIX;
         end
         pdtg_pkg::ST_SKIP_FIX: begin
            if (status.last) state_in = pdtg_pkg::ST_LOAD_SUM;
            else             state_in = pdtg_pkg::ST_IDLE;
         end
         default: state_in = pdtg_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_stall  = state_ff != pdtg_pkg::ST_IDLE;
      case (state_ff)
         pdtg_pkg::ST_IDLE:       cmd.accept     = req_valid;
         pdtg_pkg::ST_CHECK:      cmd.check      = 1'b1;
         pdtg_pkg::ST_LOAD_TRIG:  cmd.load_trig  = 1'b1;
         pdtg_pkg::ST_LOAD_SUM:   cmd.load_sum   = 1'b1;
         pdtg_pkg::ST_MUL_LO:     cmd.mul_lo     = 1'b1;
         pdtg_pkg::ST_MUL_HI:     cmd.mul_hi     = 1'b1;
         pdtg_pkg::ST_DIV_START:  cmd.time_start = 1'b1;
         pdtg_pkg::ST_EMIT:       cmd.emit       = status.out_free;
         pdtg_pkg::ST_SKIP_START: cmd.skip_start = 1'b1;
         pdtg_pkg::ST_SKIP_FIX:   cmd.skip_fix   = 1'b1;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pdtg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/core/path_distance_trigger_generator.sv
// ----------------------------------------------------------------------------
// path_distance_trigger_generator
// Fixed-distance position trigger: running path length, trigger points with
// times, per-path summary.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one path segment per transaction (length in um, last flag);
//   a transaction completes when req_valid is high and req_stall is low.
//   rsp_* carries trigger and summary results, one per transaction, same rule.
//   csr_* writes trigger spacing (index 0) and velocity (index 1) while idle.
// Sequence:
//   A segment with no result passes intake and trigger check only.
//   Each result goes through staging, two 20x20 partial products for
//   position * 1e6, the bit-serial divider for the time, and emit. A segment
//   past the per-segment trigger limit adds a remainder pass through the
//   same divider and a fixup of the next trigger. One segment in flight.
// Reset:
//   Synchronous, active high. Spacing 1000 um, velocity 10000 um/s, path
//   state cleared, next trigger at the spacing, no result pending.
// Stall:
//   A result waits in the output register; the sequencer keeps computing
//   the next result and holds it until the output register frees up.
// ----------------------------------------------------------------------------
module path_distance_trigger_generator (
   input  logic                                clock,
   input  logic                                reset,
   // segment input
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [pdtg_pkg::LEN_W-1:0]          req_segment_length_um,
   input  logic                                req_last_segment,
   // result output
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_kind,
   output logic [pdtg_pkg::POS_W-1:0]          rsp_position_um,
   output logic [pdtg_pkg::TIME_W-1:0]         rsp_time_us,
   output logic [pdtg_pkg::SEG_OUT_W-1:0]      rsp_segment_number,
   output logic [pdtg_pkg::TOTAL_W-1:0]        rsp_trigger_total,
   output logic                                rsp_overflow,
   output logic                                rsp_last_result,
   // configuration
   input  logic                                csr_write_enable,
   input  logic [pdtg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pdtg_pkg::LEN_W-1:0]          csr_write_data
);

   pdtg_pkg::cmd_type    cmd;
   pdtg_pkg::status_type status;

   // sequencer: one segment at a time, one result at a time
   pdtg_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // path state, arithmetic and output register
   pdtg_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_segment_length_um (req_segment_length_um),
      .req_last_segment      (req_last_segment),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_kind              (rsp_kind),
      .rsp_position_um       (rsp_position_um),
      .rsp_time_us           (rsp_time_us),
      .rsp_segment_number    (rsp_segment_number),
      .rsp_trigger_total     (rsp_trigger_total),
      .rsp_overflow          (rsp_overflow),
      .rsp_last_result       (rsp_last_result)
   );

endmodule
